[hdl/rti_pkg.sv]
// Shared types and constants for the ray/triangle intersection pipeline.
// Used by every module of the block; depends on nothing.
package rti_pkg;

    localparam int CW   = 20;          // coordinate width, Q10.10
    localparam int FB   = 10;          // coordinate fraction bits
    localparam int NW   = 16;          // normal component width, Q2.14
    localparam int NFB  = 14;          // normal fraction bits
    localparam int EW   = 10;          // epsilon width
    localparam int QW   = CW - 1;      // width of t and of the far limit
    localparam int EXT  = CW + 1;      // edge and offset vector width
    localparam int PW   = 2 * EXT;     // one cross product term
    localparam int CRW  = PW + 1;      // cross product component
    localparam int LOW  = 22;          // low slice of a cross component
    localparam int HIW  = CRW - LOW;   // high slice of a cross component
    localparam int DW   = 66;          // determinant width
    localparam int ES   = DW / 3;      // determinant slice for epsilon scaling
    localparam int EDW  = DW + FB;     // epsilon-scaled determinant width
    localparam int RW   = DW + QW;     // divider remainder width
    localparam int NDP  = NW + CW;     // one normal-direction product
    localparam int NDW  = NDP + 2;     // normal-direction dot product
    localparam int PDW  = QW + 1 + CW; // t times direction
    localparam int CFG_DW  = 3 * CW;
    localparam int CFG_IW  = 3;
    localparam int NRM_REGW = 3 * NW;

    localparam logic [CFG_IW-1:0] CFG_VERTEX_A = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_VERTEX_B = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_VERTEX_C = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_NORMAL   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_EPSILON  = 3'd4;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [NW-1:0]  t_norm;
    typedef t_coord [2:0]          t_vec;
    typedef t_norm  [2:0]          t_nvec;
    typedef logic signed [DW-1:0]  t_wide;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic [QW-1:0]        far_limit;
    } t_ray_in;

    typedef struct packed {
        logic                 hit;
        logic [QW-1:0]        hit_t;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic signed [NW-1:0] facing_normal_x;
        logic signed [NW-1:0] facing_normal_y;
        logic signed [NW-1:0] facing_normal_z;
    } t_result;

    // Ray data that rides along the pipeline until the hit point is formed.
    typedef struct packed {
        t_vec          o;
        t_vec          d;
        logic [QW-1:0] far;
        logic          nflip;
    } t_side;

    typedef struct packed {
        logic  valid;
        logic  pmiss;
        t_wide det;
        t_wide nb;
        t_wide ng;
        t_wide nt;
        t_side side;
    } t_det_beat;

    typedef struct packed {
        logic          valid;
        logic          ok;
        logic [RW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] q;
        t_side         side;
    } t_div_beat;

endpackage

[hdl/ray_triangle_intersect.sv]
// Top level of the ray/triangle intersection engine: triangle registers,
// the pipeline chain and the hit point output stages. Uses rti_pkg.
//
// One ray is taken on every clock edge where start is high and busy is low; busy
// is only high while the block comes out of reset. Each ray gives exactly one
// result beat, marked by o_result_valid for one cycle, in order. The pipeline
// has five stages for the determinants, four for the tests, nineteen for the
// quotient bits of t (one restoring step per stage), and two for the hit
// point. The receiver cannot hold results off, so it must take a beat whenever
// o_result_valid is high. The triangle registers are read live by the pipeline;
// write them only while no ray is in flight.
module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_ray_in           i_ray,
    output logic              o_result_valid,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_norm  N_MAX = {1'b0, {(NW-1){1'b1}}};
    localparam t_norm  N_MIN = {1'b1, {(NW-1){1'b0}}};

    function automatic t_coord sat_coord(input logic signed [PDW:0] v);
        if (v > (PDW+1)'(C_MAX)) begin
            return C_MAX;
        end else if (v < (PDW+1)'(C_MIN)) begin
            return C_MIN;
        end
        return v[CW-1:0];
    endfunction

    function automatic t_norm neg_norm(input t_norm v);
        return (v == N_MIN) ? N_MAX : -v;
    endfunction

    // Triangle registers.
    t_vec          r_va, r_vb, r_vc;
    t_nvec         r_nrm;
    logic [EW-1:0] r_eps;
    logic          r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= '0;
            r_vb    <= '0;
            r_vc    <= '0;
            r_nrm   <= '0;
            r_eps   <= EW'(1);
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VERTEX_A: r_va  <= i_cfg_data;
                    CFG_VERTEX_B: r_vb  <= i_cfg_data;
                    CFG_VERTEX_C: r_vc  <= i_cfg_data;
                    CFG_NORMAL:   r_nrm <= i_cfg_data[NRM_REGW-1:0];
                    CFG_EPSILON:  r_eps <= i_cfg_data[EW-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = !r_ready;

    t_det_beat w_det;
    t_div_beat w_test, w_div;

    rti_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_ray   (i_ray),
        .i_va    (r_va),
        .i_vb    (r_vb),
        .i_vc    (r_vc),
        .i_nrm   (r_nrm),
        .i_eps   (r_eps),
        .o_beat  (w_det)
    );

    rti_test u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_det),
        .i_eps   (r_eps),
        .o_beat  (w_test)
    );

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_test),
        .o_beat  (w_div)
    );

    // First output stage: far limit test and t times direction.
    logic signed [PDW-1:0] n_p_prod [3];
    logic          r_p_valid, r_p_ok, r_p_nflip;
    logic signed [PDW-1:0] r_p_prod [3];
    logic [QW-1:0] r_p_q;
    t_vec          r_p_o;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p_prod[i] = $signed({1'b0, w_div.q}) * $signed(w_div.side.d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= w_div.valid;
        end
        r_p_ok    <= w_div.ok && (w_div.q < w_div.side.far);
        r_p_prod  <= n_p_prod;
        r_p_q     <= w_div.q;
        r_p_o     <= w_div.side.o;
        r_p_nflip <= w_div.side.nflip;
    end

    // Second output stage: hit point, facing normal, zeros on a miss.
    t_coord  n_hp [3];
    t_norm   n_fn [3];
    t_result n_res;
    logic    r_res_valid;
    t_result r_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_hp[i] = sat_coord((PDW+1)'($signed(r_p_o[i])) + (PDW+1)'(r_p_prod[i] >>> FB));
            n_fn[i] = r_p_nflip ? neg_norm(r_nrm[i]) : r_nrm[i];
        end
        n_res = '0;
        if (r_p_ok) begin
            n_res.hit             = 1'b1;
            n_res.hit_t           = r_p_q;
            n_res.hit_x           = n_hp[0];
            n_res.hit_y           = n_hp[1];
            n_res.hit_z           = n_hp[2];
            n_res.facing_normal_x = n_fn[0];
            n_res.facing_normal_y = n_fn[1];
            n_res.facing_normal_z = n_fn[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_p_valid;
        end
        r_res <= n_res;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.hit |->
            o_result.hit_t == '0 && o_result.hit_x == '0 && o_result.hit_y == '0 &&
            o_result.hit_z == '0 && o_result.facing_normal_x == '0 &&
            o_result.facing_normal_y == '0 && o_result.facing_normal_z == '0)
        else $error("miss beat carries nonzero fields");

    a_normal_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.hit |->
            o_result.facing_normal_x == r_nrm[0] ||
            o_result.facing_normal_x == -r_nrm[0] ||
            (r_nrm[0] == N_MIN && o_result.facing_normal_x == N_MAX))
        else $error("facing normal does not match the triangle normal");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result beat right after reset");
`endif

endmodule

[hdl/rti_det.sv]
// Front end of the intersection pipeline: edge vectors, cross products and
// the four Cramer determinants over five register stages. Uses rti_pkg.
module rti_det
    import rti_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_ray_in       i_ray,
    input  t_vec          i_va,
    input  t_vec          i_vb,
    input  t_vec          i_vc,
    input  t_nvec         i_nrm,
    input  logic [EW-1:0] i_eps,
    output t_det_beat     o_beat
);

    typedef logic signed [EXT-1:0] t_ext;
    typedef logic signed [PW-1:0]  t_prod;
    typedef logic signed [CRW-1:0] t_cross;

    function automatic logic [1:0] nxt(input logic [1:0] j);
        return (j == 2'd2) ? 2'd0 : j + 2'd1;
    endfunction

    // Stage A: differences and normal-direction products.
    t_vec v_o, v_d;
    t_ext n_a_e1 [3], n_a_e2 [3], n_a_r [3], n_a_d [3];
    logic signed [NDP-1:0] n_a_pnd [3];
    logic r_a_valid;
    t_ext r_a_e1 [3], r_a_e2 [3], r_a_r [3], r_a_d [3];
    logic signed [NDP-1:0] r_a_pnd [3];
    t_side r_a_side;

    assign v_o = {i_ray.origin_z, i_ray.origin_y, i_ray.origin_x};
    assign v_d = {i_ray.dir_z, i_ray.dir_y, i_ray.dir_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_e1[i]  = EXT'($signed(i_va[i])) - EXT'($signed(i_vb[i]));
            n_a_e2[i]  = EXT'($signed(i_va[i])) - EXT'($signed(i_vc[i]));
            n_a_r[i]   = EXT'($signed(i_va[i])) - EXT'($signed(v_o[i]));
            n_a_d[i]   = EXT'($signed(v_d[i]));
            n_a_pnd[i] = $signed(i_nrm[i]) * $signed(v_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_e1   <= n_a_e1;
        r_a_e2   <= n_a_e2;
        r_a_r    <= n_a_r;
        r_a_d    <= n_a_d;
        r_a_pnd  <= n_a_pnd;
        r_a_side <= '{o: v_o, d: v_d, far: i_ray.far_limit, nflip: 1'b0};
    end

    // Stage B: cross product terms of (e2 x d), (r x d) and (e2 x r).
    t_ext  u_sel [3][3], w_sel [3][3];
    t_prod n_b_pp [3][3][2];
    logic signed [NDW-1:0] n_b_ndot;
    logic  r_b_valid;
    t_prod r_b_pp [3][3][2];
    logic signed [NDW-1:0] r_b_ndot;
    t_ext  r_b_e1 [3], r_b_r [3];
    t_side r_b_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            u_sel[0][j] = r_a_e2[j];
            w_sel[0][j] = r_a_d[j];
            u_sel[1][j] = r_a_r[j];
            w_sel[1][j] = r_a_d[j];
            u_sel[2][j] = r_a_e2[j];
            w_sel[2][j] = r_a_r[j];
        end
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 3; j++) begin
                n_b_pp[c][j][0] = u_sel[c][nxt(2'(j))] * w_sel[c][nxt(nxt(2'(j)))];
                n_b_pp[c][j][1] = u_sel[c][nxt(nxt(2'(j)))] * w_sel[c][nxt(2'(j))];
            end
        end
        n_b_ndot = NDW'(r_a_pnd[0]) + NDW'(r_a_pnd[1]) + NDW'(r_a_pnd[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_pp   <= n_b_pp;
        r_b_ndot <= n_b_ndot;
        r_b_e1   <= r_a_e1;
        r_b_r    <= r_a_r;
        r_b_side <= r_a_side;
    end

    // Stage C: cross components and the near-parallel test.
    t_cross n_c_x [3][3];
    logic signed [NDW-1:0] n_c_abs;
    logic   n_c_pmiss;
    t_side  n_c_side;
    logic   r_c_valid, r_c_pmiss;
    t_cross r_c_x [3][3];
    t_ext   r_c_e1 [3], r_c_r [3];
    t_side  r_c_side;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 3; j++) begin
                n_c_x[c][j] = CRW'(r_b_pp[c][j][0]) - CRW'(r_b_pp[c][j][1]);
            end
        end
        n_c_abs   = (r_b_ndot < 0) ? -r_b_ndot : r_b_ndot;
        n_c_pmiss = $unsigned(n_c_abs) < NDW'({i_eps, {NFB{1'b0}}});
        n_c_side  = r_b_side;
        n_c_side.nflip = (r_b_ndot > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_x     <= n_c_x;
        r_c_pmiss <= n_c_pmiss;
        r_c_e1    <= r_b_e1;
        r_c_r     <= r_b_r;
        r_c_side  <= n_c_side;
    end

    // Stage D: dot product partials, each cross component cut into two slices.
    // Order of the dots: det = e1.X0, nb = r.X0, ng = e1.X1, nt = e1.X2.
    t_ext   du [4][3];
    t_cross dx [4][3];
    logic signed [EXT+HIW-1:0]   n_d_ph [4][3];
    logic signed [EXT+LOW:0]     n_d_pl [4][3];
    logic   r_d_valid, r_d_pmiss;
    logic signed [EXT+HIW-1:0]   r_d_ph [4][3];
    logic signed [EXT+LOW:0]     r_d_pl [4][3];
    t_side  r_d_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            du[0][j] = r_c_e1[j];
            dx[0][j] = r_c_x[0][j];
            du[1][j] = r_c_r[j];
            dx[1][j] = r_c_x[0][j];
            du[2][j] = r_c_e1[j];
            dx[2][j] = r_c_x[1][j];
            du[3][j] = r_c_e1[j];
            dx[3][j] = r_c_x[2][j];
        end
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_d_ph[k][j] = du[k][j] * $signed(dx[k][j][CRW-1:LOW]);
                n_d_pl[k][j] = du[k][j] * $signed({1'b0, dx[k][j][LOW-1:0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_ph    <= n_d_ph;
        r_d_pl    <= n_d_pl;
        r_d_pmiss <= r_c_pmiss;
        r_d_side  <= r_c_side;
    end

    // Stage E: sum the partials into the four determinants.
    t_wide n_e_dot [4];
    t_wide acc;
    t_det_beat r_e_beat;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                acc = acc + (DW'(r_d_ph[k][j]) <<< LOW) + DW'(r_d_pl[k][j]);
            end
            n_e_dot[k] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_beat.valid <= 1'b0;
        end else begin
            r_e_beat.valid <= r_d_valid;
        end
        r_e_beat.pmiss <= r_d_pmiss;
        r_e_beat.det   <= n_e_dot[0];
        r_e_beat.nb    <= n_e_dot[1];
        r_e_beat.ng    <= n_e_dot[2];
        r_e_beat.nt    <= n_e_dot[3];
        r_e_beat.side  <= r_d_side;
    end

    assign o_beat = r_e_beat;

endmodule

[hdl/rti_test.sv]
// Inside tests of the intersection pipeline: sign normalization, epsilon and
// barycentric tests and the divider setup over four stages. Uses rti_pkg.
module rti_test
    import rti_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_det_beat     i_beat,
    input  logic [EW-1:0] i_eps,
    output t_div_beat     o_beat
);

    // Stage F: make the determinant positive.
    logic  n_f_neg;
    logic  r_f_valid, r_f_miss;
    t_wide r_f_det, r_f_nb, r_f_ng, r_f_nt;
    t_side r_f_side;

    assign n_f_neg = i_beat.det[DW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= i_beat.valid;
        end
        r_f_miss <= i_beat.pmiss || (i_beat.det == '0);
        r_f_det  <= n_f_neg ? -i_beat.det : i_beat.det;
        r_f_nb   <= n_f_neg ? -i_beat.nb  : i_beat.nb;
        r_f_ng   <= n_f_neg ? -i_beat.ng  : i_beat.ng;
        r_f_nt   <= n_f_neg ? -i_beat.nt  : i_beat.nt;
        r_f_side <= i_beat.side;
    end

    // Stage G: epsilon times det in slices, beta+gamma < 1, and whether t
    // already reaches the top of the divider range.
    logic [EW+ES-1:0]    n_g_p [3];
    logic signed [DW:0]  n_g_sum;
    logic [RW-1:0]       n_g_num, n_g_top;
    logic  r_g_valid, r_g_miss, r_g_bg, r_g_over;
    logic [EW+ES-1:0]    r_g_p [3];
    logic [RW-1:0]       r_g_num;
    t_wide r_g_det, r_g_nb, r_g_ng, r_g_nt;
    t_side r_g_side;

    always_comb begin
        for (int s = 0; s < 3; s++) begin
            n_g_p[s] = i_eps * r_f_det[s*ES +: ES];
        end
        n_g_sum = (DW+1)'(r_f_nb) + (DW+1)'(r_f_ng);
        n_g_num = RW'(r_f_nt[DW-2:0]) << FB;
        n_g_top = RW'(r_f_det[DW-2:0]) << QW;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= r_f_valid;
        end
        r_g_miss <= r_f_miss;
        r_g_bg   <= n_g_sum < (DW+1)'(r_f_det);
        r_g_over <= n_g_num >= n_g_top;
        r_g_p    <= n_g_p;
        r_g_num  <= n_g_num;
        r_g_det  <= r_f_det;
        r_g_nb   <= r_f_nb;
        r_g_ng   <= r_f_ng;
        r_g_nt   <= r_f_nt;
        r_g_side <= r_f_side;
    end

    // Stage H: assemble epsilon times det.
    logic  r_h_valid, r_h_miss, r_h_bg, r_h_over;
    logic [EDW-1:0] r_h_epsd;
    logic [RW-1:0]  r_h_num;
    t_wide r_h_det, r_h_nb, r_h_ng, r_h_nt;
    t_side r_h_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else begin
            r_h_valid <= r_g_valid;
        end
        r_h_epsd <= EDW'(r_g_p[0]) + (EDW'(r_g_p[1]) << ES) + (EDW'(r_g_p[2]) << (2 * ES));
        r_h_miss <= r_g_miss;
        r_h_bg   <= r_g_bg;
        r_h_over <= r_g_over;
        r_h_num  <= r_g_num;
        r_h_det  <= r_g_det;
        r_h_nb   <= r_g_nb;
        r_h_ng   <= r_g_ng;
        r_h_nt   <= r_g_nt;
        r_h_side <= r_g_side;
    end

    // Stage I: beta, gamma and t must all exceed epsilon.
    logic n_i_cb, n_i_cg, n_i_ct;
    t_div_beat r_i_beat;

    always_comb begin
        n_i_cb = $signed({r_h_nb, {FB{1'b0}}}) > $signed(r_h_epsd);
        n_i_cg = $signed({r_h_ng, {FB{1'b0}}}) > $signed(r_h_epsd);
        n_i_ct = $signed({r_h_nt, {FB{1'b0}}}) > $signed(r_h_epsd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_beat.valid <= 1'b0;
        end else begin
            r_i_beat.valid <= r_h_valid;
        end
        r_i_beat.ok   <= !r_h_miss && r_h_bg && !r_h_over && n_i_cb && n_i_cg && n_i_ct;
        r_i_beat.rem  <= r_h_num;
        r_i_beat.den  <= r_h_det;
        r_i_beat.q    <= '0;
        r_i_beat.side <= r_h_side;
    end

    assign o_beat = r_i_beat;

endmodule

[hdl/rti_div.sv]
// Pipelined restoring divider for t = (nt << F) / det, one quotient bit per
// stage, most significant first. Uses rti_pkg.
module rti_div
    import rti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_beat i_beat,
    output t_div_beat o_beat
);

    t_div_beat n_st [QW];
    t_div_beat r_st [QW];
    t_div_beat src;
    logic [RW-1:0] cand;

    // The setup stage clears ok unless rem < det << QW, so QW bits hold the quotient of every ok beat.
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            src  = (s == 0) ? i_beat : r_st[(s == 0) ? 0 : s - 1];
            cand = RW'(src.den) << (QW - 1 - s);
            n_st[s] = src;
            if (src.rem >= cand) begin
                n_st[s].rem = src.rem - cand;
                n_st[s].q[QW-1-s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QW; s++) begin
            if (!i_rst_n) begin
                r_st[s].valid <= 1'b0;
            end else begin
                r_st[s].valid <= n_st[s].valid;
            end
            r_st[s].ok   <= n_st[s].ok;
            r_st[s].rem  <= n_st[s].rem;
            r_st[s].den  <= n_st[s].den;
            r_st[s].q    <= n_st[s].q;
            r_st[s].side <= n_st[s].side;
        end
    end

    assign o_beat = r_st[QW-1];

endmodule
